### src/pfe_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// Used by pfe_alu and postfix_expression_evaluator; no dependencies.
package pfe_pkg;

	localparam int WORD_W = 32;

	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_MUL   = 8'h2A;
	localparam logic [7:0] SYM_DIV   = 8'h2F;
	localparam logic [7:0] SYM_POW   = 8'h5E;
	localparam logic [7:0] SYM_ZERO  = 8'h30;
	localparam logic [7:0] SYM_NINE  = 8'h39;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [1:0] ST_DIV_ZERO  = 2'd3;

	localparam logic REG_STACK_CAPACITY = 1'b0;
	localparam logic [6:0] CAPACITY_RESET = 7'd64;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_POW
	} alu_op_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] result;
		logic              div_zero;
	} alu_rsp_t;

	function automatic logic is_op(input logic [7:0] sym);
		return (sym == SYM_PLUS) || (sym == SYM_MINUS) || (sym == SYM_MUL) ||
			(sym == SYM_DIV) || (sym == SYM_POW);
	endfunction

	function automatic logic is_digit(input logic [7:0] sym);
		return (sym >= SYM_ZERO) && (sym <= SYM_NINE);
	endfunction

endpackage

### src/pfe_alu.sv
// Iterative arithmetic unit: registered multiply, restoring divide, square-and-multiply power.
// A single 32x32 low-product multiplier serves multiply and power. Depends on pfe_pkg.
module pfe_alu import pfe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_DIV,
		A_DIV_FIX,
		A_POW_R,
		A_POW_B,
		A_DONE
	} astate_t;

	astate_t           state_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] y_q;
	logic [WORD_W-1:0] e_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] res_q;
	logic [4:0]        cnt_q;
	logic              neg_q;
	logic              div0_q;

	logic [WORD_W-1:0]   mul_a;
	logic [2*WORD_W-1:0] mul_full;
	logic [WORD_W-1:0]   prod;
	logic [WORD_W:0]     rem_sh;
	logic [WORD_W:0]     rem_dif;
	logic                qbit;
	logic [WORD_W-1:0]   mag_a;
	logic [WORD_W-1:0]   mag_b;

	assign mul_a    = (state_q == A_POW_B) ? y_q : x_q;
	assign mul_full = mul_a * y_q;
	assign prod     = mul_full[WORD_W-1:0];

	// one restoring divide step; x_q shifts the dividend out and the quotient in
	assign rem_sh  = {rem_q, x_q[WORD_W-1]};
	assign rem_dif = rem_sh - {1'b0, y_q};
	assign qbit    = ~rem_dif[WORD_W];

	assign mag_a = req.a[WORD_W-1] ? (WORD_W'(0) - req.a) : req.a;
	assign mag_b = req.b[WORD_W-1] ? (WORD_W'(0) - req.b) : req.b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			div0_q  <= 1'b0;
		end else begin
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						div0_q <= 1'b0;
						unique case (req.op)
							ALU_MUL: begin
								x_q     <= req.a;
								y_q     <= req.b;
								state_q <= A_MUL;
							end
							ALU_DIV: begin
								if (req.b == '0) begin
									res_q   <= '0;
									div0_q  <= 1'b1;
									state_q <= A_DONE;
								end else begin
									x_q     <= mag_a;
									y_q     <= mag_b;
									rem_q   <= '0;
									cnt_q   <= '0;
									neg_q   <= req.a[WORD_W-1] ^ req.b[WORD_W-1];
									state_q <= A_DIV;
								end
							end
							default: begin
								if (req.b[WORD_W-1]) begin
									// negative exponent
									if (req.a == WORD_W'(1))
										res_q <= WORD_W'(1);
									else if (req.a == '1)
										res_q <= req.b[0] ? '1 : WORD_W'(1);
									else
										res_q <= '0;
									div0_q  <= (req.a == '0);
									state_q <= A_DONE;
								end else begin
									x_q     <= WORD_W'(1);
									y_q     <= req.a;
									e_q     <= req.b;
									state_q <= A_POW_R;
								end
							end
						endcase
					end
				end
				A_MUL: begin
					res_q   <= prod;
					state_q <= A_DONE;
				end
				A_DIV: begin
					x_q   <= {x_q[WORD_W-2:0], qbit};
					rem_q <= qbit ? rem_dif[WORD_W-1:0] : rem_sh[WORD_W-1:0];
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31)
						state_q <= A_DIV_FIX;
				end
				A_DIV_FIX: begin
					res_q   <= neg_q ? (WORD_W'(0) - x_q) : x_q;
					state_q <= A_DONE;
				end
				A_POW_R: begin
					if (e_q == '0) begin
						res_q   <= x_q;
						state_q <= A_DONE;
					end else begin
						if (e_q[0])
							x_q <= prod;
						state_q <= A_POW_B;
					end
				end
				A_POW_B: begin
					y_q     <= prod;
					e_q     <= {1'b0, e_q[WORD_W-1:1]};
					state_q <= A_POW_R;
				end
				A_DONE: begin
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign rsp.done     = (state_q == A_DONE);
	assign rsp.result   = res_q;
	assign rsp.div_zero = div0_q;

endmodule

### src/postfix_expression_evaluator.sv
// Postfix expression evaluator: one ASCII character per input item, a signed 32-bit operand
// stack in a single-port-read memory, and a sticky status. A digit or other non-operator
// character is pushed, an operator that finds fewer than two operands sets the underflow
// status, + and - are done in place, and *, / and ^ go to the shared unit: / runs 32
// restoring divide steps there unless the divisor is zero, and ^ alternates square and
// multiply on the one shared multiplier unless the exponent is negative. The character
// marked last is followed by a pop of the result and a load of the output register; the
// next expression's characters are accepted while that result waits on the output.
// Depends on pfe_pkg and pfe_alu.
module postfix_expression_evaluator import pfe_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tlast,   // end_of_expression
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] result_value, [33:32] status, rest zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int AW  = $clog2(STACK_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_L,
		S_OPS,
		S_ALU,
		S_PUSH,
		S_POP,
		S_POP_RD,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [SPW-1:0]    sp_q;
	logic [1:0]        err_q;
	logic [6:0]        cap_q;
	logic [7:0]        sym_q;
	logic              last_q;
	logic [WORD_W-1:0] right_q;
	logic [WORD_W-1:0] res_q;
	logic              m_valid_q;
	logic [WORD_W-1:0] out_res_q;
	logic [1:0]        out_st_q;

	logic [WORD_W-1:0] mem_q [STACK_DEPTH];
	logic [WORD_W-1:0] rdata_q;

	logic              in_acc;
	logic              out_free;
	logic [SPW-1:0]    sp_m1;
	logic [SPW-1:0]    sp_m2;
	logic [SPW-1:0]    cap_eff;
	logic              can_push;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [7:0]        digit_val;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !m_valid_q || m_axis_tready;
	assign sp_m1     = sp_q - SPW'(1);
	assign sp_m2     = sp_q - SPW'(2);
	assign digit_val = s_axis_tdata - SYM_ZERO;

	always_comb begin
		if (cap_q == '0)
			cap_eff = SPW'(1);
		else if (32'(cap_q) > 32'(STACK_DEPTH))
			cap_eff = SPW'(STACK_DEPTH);
		else
			cap_eff = SPW'(cap_q);
	end

	assign can_push = (sp_q < cap_eff);

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_STACK_CAPACITY) ? {25'b0, cap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cap_q <= CAPACITY_RESET;
		else if (psel && penable && pwrite && pready && paddr[2] == REG_STACK_CAPACITY)
			cap_q <= pwdata[6:0];
	end

	// stack memory
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = sp_m1[AW-1:0];
		unique case (state_q)
			S_IDLE: rd_en = in_acc && is_op(s_axis_tdata) && (sp_q >= SPW'(2));
			S_RD_L: begin
				rd_en   = 1'b1;
				rd_addr = sp_m2[AW-1:0];
			end
			S_POP:   rd_en = (sp_q != '0);
			default: rd_en = 1'b0;
		endcase
	end

	assign wr_en = (state_q == S_PUSH) && can_push;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[sp_q[AW-1:0]] <= res_q;
		if (rd_en)
			rdata_q <= mem_q[rd_addr];
	end

	// shared arithmetic unit
	always_comb begin
		alu_req.start = (state_q == S_OPS) &&
			(sym_q == SYM_MUL || sym_q == SYM_DIV || sym_q == SYM_POW);
		alu_req.a = rdata_q;
		alu_req.b = right_q;
		if (sym_q == SYM_MUL)
			alu_req.op = ALU_MUL;
		else if (sym_q == SYM_DIV)
			alu_req.op = ALU_DIV;
		else
			alu_req.op = ALU_POW;
	end

	pfe_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sp_q      <= '0;
			err_q     <= ST_OK;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready && state_q != S_EMIT)
				m_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						sym_q  <= s_axis_tdata;
						last_q <= s_axis_tlast;
						if (is_op(s_axis_tdata)) begin
							if (sp_q < SPW'(2)) begin
								if (err_q == ST_OK)
									err_q <= ST_UNDERFLOW;
								state_q <= s_axis_tlast ? S_POP : S_IDLE;
							end else begin
								state_q <= S_RD_L;
							end
						end else begin
							res_q   <= is_digit(s_axis_tdata) ?
								{{(WORD_W-8){1'b0}}, digit_val} : '0;
							state_q <= S_PUSH;
						end
					end
				end
				S_RD_L: begin
					right_q <= rdata_q;
					state_q <= S_OPS;
				end
				S_OPS: begin
					sp_q <= sp_m2;
					unique case (sym_q)
						SYM_PLUS: begin
							res_q   <= rdata_q + right_q;
							state_q <= S_PUSH;
						end
						SYM_MINUS: begin
							res_q   <= rdata_q - right_q;
							state_q <= S_PUSH;
						end
						default: state_q <= S_ALU;
					endcase
				end
				S_ALU: begin
					if (alu_rsp.done) begin
						res_q <= alu_rsp.result;
						if (alu_rsp.div_zero && err_q == ST_OK)
							err_q <= ST_DIV_ZERO;
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (can_push)
						sp_q <= sp_q + SPW'(1);
					else if (err_q == ST_OK)
						err_q <= ST_OVERFLOW;
					state_q <= last_q ? S_POP : S_IDLE;
				end
				S_POP: begin
					if (sp_q == '0) begin
						if (err_q == ST_OK)
							err_q <= ST_UNDERFLOW;
						res_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						sp_q    <= sp_m1;
						state_q <= S_POP_RD;
					end
				end
				S_POP_RD: begin
					res_q   <= rdata_q;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_res_q <= res_q;
						out_st_q  <= err_q;
						m_valid_q <= 1'b1;
						sp_q      <= '0;
						err_q     <= ST_OK;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'b0, out_st_q, out_res_q};

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= 32'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK) |=> (err_q == $past(err_q) || err_q == ST_OK))
		else $error("status code replaced within an expression");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_free) |=> (sp_q == '0 && err_q == ST_OK && m_valid_q))
		else $error("stack not cleared after result");

	a_alu_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == S_ALU))
		else $error("arithmetic unit finished outside its wait state");

endmodule

### tb/postfix_expression_evaluator_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the postfix expression evaluator: watches the symbol stream, the result
// stream and APB writes, keeps its own operand stack and flags result mismatches.
// Depends on pfe_pkg for symbol, status and register codes.
module postfix_expression_evaluator_checker import pfe_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  logic        s_axis_tlast,   // end_of_expression
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,   // [31:0] result_value, [33:32] status, rest zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatch_count,
	output int          results_pending
);

	localparam logic [2:0] CAPACITY_ADDR = {REG_STACK_CAPACITY, 2'b00};

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
	} expr_result_t;

	expr_result_t expected_results[$];
	logic [31:0]  operand_mem[STACK_DEPTH];
	int unsigned  operand_count;
	logic [1:0]   sticky_status;
	logic [6:0]   capacity;
	int           mismatches;

	function automatic void flag_error(input logic [1:0] code);
		if (sticky_status == ST_OK)
			sticky_status = code;
	endfunction

	function automatic int unsigned usable_capacity();
		int unsigned c;
		c = capacity;
		if (c < 1)
			c = 1;
		if (c > STACK_DEPTH)
			c = STACK_DEPTH;
		return c;
	endfunction

	function automatic void push_operand(input logic [31:0] value);
		if (operand_count >= usable_capacity()) begin
			flag_error(ST_OVERFLOW);
		end else begin
			operand_mem[operand_count] = value;
			operand_count++;
		end
	endfunction

	function automatic logic [31:0] divide_word(input logic [31:0] lhs, input logic [31:0] rhs);
		logic [31:0] lmag, rmag, quot;
		lmag = lhs[31] ? -lhs : lhs;
		rmag = rhs[31] ? -rhs : rhs;
		if (rhs == 32'd0) begin
			flag_error(ST_DIV_ZERO);
			return 32'd0;
		end
		quot = lmag / rmag;
		return (lhs[31] != rhs[31]) ? -quot : quot;
	endfunction

	function automatic logic [31:0] power_word(input logic [31:0] base, input logic [31:0] expo);
		logic [31:0] acc, b, e;
		if (expo[31]) begin
			if (base == 32'd1)
				return 32'd1;
			if (base == 32'hFFFF_FFFF)
				return expo[0] ? 32'hFFFF_FFFF : 32'd1;
			if (base == 32'd0)
				flag_error(ST_DIV_ZERO);
			return 32'd0;
		end
		acc = 32'd1;
		b = base;
		e = expo;
		while (e != 32'd0) begin
			if (e[0])
				acc = acc * b;
			b = b * b;
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic void apply_symbol(input logic [7:0] sym);
		logic [31:0] lhs, rhs, res;
		case (sym)
			SYM_PLUS, SYM_MINUS, SYM_MUL, SYM_DIV, SYM_POW: begin
				if (operand_count < 2) begin
					flag_error(ST_UNDERFLOW);
				end else begin
					rhs = operand_mem[operand_count - 1];
					lhs = operand_mem[operand_count - 2];
					operand_count -= 2;
					case (sym)
						SYM_PLUS:  res = lhs + rhs;
						SYM_MINUS: res = lhs - rhs;
						SYM_MUL:   res = lhs * rhs;
						SYM_DIV:   res = divide_word(lhs, rhs);
						default:   res = power_word(lhs, rhs);
					endcase
					push_operand(res);
				end
			end
			default: begin
				if (sym >= SYM_ZERO && sym <= SYM_NINE)
					push_operand({24'd0, sym - SYM_ZERO});
				else
					push_operand(32'd0);
			end
		endcase
	endfunction

	function automatic expr_result_t close_expression();
		expr_result_t r;
		r.value = 32'd0;
		if (operand_count == 0) begin
			flag_error(ST_UNDERFLOW);
		end else begin
			operand_count--;
			r.value = operand_mem[operand_count];
		end
		r.status = sticky_status;
		operand_count = 0;
		sticky_status = ST_OK;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		expr_result_t exp_r;
		if (!arst_n) begin
			expected_results.delete();
			operand_count = 0;
			sticky_status = ST_OK;
			capacity = CAPACITY_RESET;
			mismatches = 0;
			mismatch_count <= 0;
			results_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
				capacity = pwdata[6:0];
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result item, expected none, actual value %0d status %0d",
						$time, $signed(m_axis_tdata[31:0]), m_axis_tdata[33:32]);
				end else begin
					exp_r = expected_results.pop_front();
					if (m_axis_tdata[31:0] !== exp_r.value) begin
						mismatches++;
						$display("%0t: result_value expected %0d actual %0d", $time,
							$signed(exp_r.value), $signed(m_axis_tdata[31:0]));
					end
					if (m_axis_tdata[33:32] !== exp_r.status) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d", $time,
							exp_r.status, m_axis_tdata[33:32]);
					end
					if (m_axis_tdata[39:34] !== 6'd0) begin
						mismatches++;
						$display("%0t: tdata padding expected 0 actual %0h", $time,
							m_axis_tdata[39:34]);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				apply_symbol(s_axis_tdata);
				if (s_axis_tlast)
					expected_results.push_back(close_expression());
			end
			mismatch_count <= mismatches;
			results_pending <= expected_results.size();
		end
	end

endmodule

### tb/postfix_expression_evaluator_test.sv
`timescale 1ns / 100ps
// Top of the postfix expression evaluator testbench: clock, reset, APB capacity writes,
// symbol stimulus and result back-pressure. Checking lives in
// postfix_expression_evaluator_checker; depends on pfe_pkg and the block itself.
module postfix_expression_evaluator_test import pfe_pkg::*;;

	localparam int         STACK_DEPTH   = 64;
	localparam logic [2:0] CAPACITY_ADDR = {REG_STACK_CAPACITY, 2'b00};
	localparam int         DRAIN_CYCLES  = 100;
	localparam int         HOLD_CYCLES   = 400;
	localparam int         QUIET_LIMIT   = 4000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          mismatch_count;
	int          results_pending;
	bit          hold_req = 1'b0;
	bit          sink_idle_en = 1'b1;
	bit          src_idle_en = 1'b1;
	logic [7:0]  expr_syms[$];

	always #1 clk = ~clk;

	postfix_expression_evaluator #(.STACK_DEPTH(STACK_DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	postfix_expression_evaluator_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatch_count(mismatch_count), .results_pending(results_pending)
	);

	task automatic send_item(input logic [7:0] sym, input logic last);
		if (src_idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= sym;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_expression(input bit mark_last);
		int n;
		n = expr_syms.size();
		for (int i = 0; i < n; i++)
			send_item(expr_syms[i], mark_last && i == n - 1);
		expr_syms.delete();
	endtask

	function automatic void append_text(input string text);
		for (int i = 0; i < text.len(); i++)
			expr_syms.push_back(text[i]);
	endfunction

	function automatic logic [7:0] random_operator();
		case ($urandom_range(0, 4))
			0:       return SYM_PLUS;
			1:       return SYM_MINUS;
			2:       return SYM_MUL;
			3:       return SYM_DIV;
			default: return SYM_POW;
		endcase
	endfunction

	function automatic logic [7:0] random_filler();
		logic [7:0] sym;
		sym = 8'($urandom_range(0, 255));
		if (is_op(sym))
			sym[7] = 1'b1;
		return sym;
	endfunction

	// postfix subtree leaving exactly one value when nothing overflows
	function automatic void build_operand(input int levels);
		int pick;
		pick = $urandom_range(0, 99);
		if (levels == 0 || pick < 35) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				expr_syms.push_back(SYM_ZERO + 8'($urandom_range(0, 9)));
			end else if (pick < 72) begin
				expr_syms.push_back(SYM_ZERO);
				expr_syms.push_back(SYM_ZERO + 8'($urandom_range(0, 9)));
				expr_syms.push_back(SYM_MINUS);
			end else if (pick < 88) begin
				expr_syms.push_back(random_filler());
			end else begin
				// 2^31 then divided by -1: most negative word
				append_text("299+9+4+^01-/");
			end
		end else begin
			build_operand(levels - 1);
			build_operand(levels - 1);
			expr_syms.push_back(random_operator());
		end
	endfunction

	task automatic run_random(input int n_items);
		int sent;
		int kind;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				build_operand($urandom_range(0, 4));
			end else if (kind < 8) begin
				build_operand(2);
				build_operand(2);
			end else begin
				repeat ($urandom_range(1, 8)) begin
					case ($urandom_range(0, 2))
						0:       expr_syms.push_back(SYM_ZERO + 8'($urandom_range(0, 9)));
						1:       expr_syms.push_back(random_operator());
						default: expr_syms.push_back(8'($urandom_range(0, 255)));
					endcase
				end
			end
			sent += expr_syms.size();
			send_expression(1'b1);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [6:0] value);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= {25'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin : result_sink
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req <= 1'b0;
				m_axis_tready <= 1'b1;
			end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'd0;
		s_axis_tlast <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 3'd0;
		pwdata <= 32'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: digit extremes, filler bytes, each operator, error cases
		append_text("9");
		send_expression(1'b1);
		append_text("0");
		send_expression(1'b1);
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);
		append_text("+");
		send_expression(1'b1);
		append_text("34+2-5*7/");
		send_expression(1'b1);
		append_text("60/");
		send_expression(1'b1);
		append_text("25^");
		send_expression(1'b1);
		append_text("50/+");
		send_expression(1'b1);
		append_text("00^");
		send_expression(1'b1);

		set_capacity(7'd1);
		append_text("12+");
		send_expression(1'b1);
		append_text("5");
		send_expression(1'b1);
		run_random(30);

		set_capacity(7'd0);
		run_random(30);

		set_capacity(7'd2);
		run_random(40);

		set_capacity(7'd127);
		run_random(40);
		hold_req <= 1'b1;
		run_random(60);

		// shrink capacity under a half-built expression
		append_text("123456");
		send_expression(1'b0);
		set_capacity(7'd3);
		append_text("7+++++");
		send_expression(1'b1);

		set_capacity(7'd65);
		run_random(40);

		repeat (3) begin
			set_capacity(7'($urandom_range(1, 64)));
			run_random(40);
		end

		set_capacity(7'd64);
		src_idle_en = 1'b0;
		sink_idle_en <= 1'b0;
		run_random(100);

		drain_results();
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### sim.f
src/pfe_pkg.sv
src/pfe_alu.sv
src/postfix_expression_evaluator.sv
tb/postfix_expression_evaluator_checker.sv
tb/postfix_expression_evaluator_test.sv
